FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and reset.
`define KVT_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion on the usual clock and reset names.
`define KVT_ASSERT(label, prop, msg) \
   `KVT_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

FILE: rtl/kvt_pkg.sv
package kvt_pkg;

   localparam int ACTION_W   = 3;
   localparam int FIELD_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int USED_W     = 5;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 40;

   localparam logic [ACTION_W-1:0] ACT_PUT          = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_GET          = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_REMOVE_KEY   = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_REMOVE_VALUE = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_CLEAR        = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_COMPACT,
      S_DONE
   } state_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic put;
      logic append;
      logic remove_key;
      logic remove_value;
      logic clear;
      logic step;
   } cell_ctrl_type;

   // Returned from every cell to the controller.
   typedef struct packed {
      logic valid;
      logic hole;
      logic key_hit;
      logic value_hit;
      logic retire;
   } cell_flags_type;

endpackage

FILE: rtl/key_value_table.sv
// Flow: a word that needs no compaction goes through S_EXEC, which writes its result word into
// the output register when that is free, else through S_DONE; a removal that hits goes through
// S_EXEC, S_COMPACT and S_DONE, and stays in S_COMPACT until every hole has retired.
// The table takes a new word only in S_IDLE, so not before the last one has left the
// controller. A stalled result word holds the next result in S_DONE until it leaves.
// Reset (synchronous, active high) empties the table and drops any pending result word.
module key_value_table #(
   parameter int ENTRIES    = 16,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request word. req_tdata, from bit 0: action[2:0], key[34:3], value[66:35],
   // zero fill[71:67].
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [kvt_pkg::REQ_DATA_W-1:0]  req_tdata,
   // Response word. rsp_tdata, from bit 0: status[1:0], value_out[33:2],
   // entries_used[38:34], zero fill[39].
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [kvt_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import kvt_pkg::*;

   localparam int COUNT_W = $clog2(ENTRIES + 1);

   // The table is a chain of cells. Valid pairs sit packed in the low cells in
   // insertion order. Every command is applied to all cells at once in the execute
   // cycle; removals leave holes that then bubble upward one cell per cycle by
   // swapping with the valid neighbor above, until they reach free space and retire.

   state_type             state_ff, state_in;
   logic [ACTION_W-1:0]   act_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [FIELD_W-1:0]    vout_ff, vout_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   cell_ctrl_type         ctrl;
   cell_flags_type        flags [ENTRIES];
   logic [KEY_BITS-1:0]   cell_key [ENTRIES];
   logic [VALUE_BITS-1:0] cell_value [ENTRIES];

   logic                  any_key_hit, any_value_hit, any_hole, any_retire;
   logic [VALUE_BITS-1:0] hit_value;
   logic                  full, slot_free, accept;

   // Fields of the request word, cut down to the configured widths.
   logic [KEY_BITS+FIELD_W-1:0]   req_key_ext;
   logic [VALUE_BITS+FIELD_W-1:0] req_value_ext;
   logic [VALUE_BITS+FIELD_W-1:0] hit_value_ext;

   assign req_key_ext   = {{KEY_BITS{1'b0}}, req_tdata[34:3]};
   assign req_value_ext = {{VALUE_BITS{1'b0}}, req_tdata[66:35]};
   assign hit_value_ext = {{FIELD_W{1'b0}}, hit_value};

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign full       = (count_ff == COUNT_W'(ENTRIES));

   // Cell chain. Cell 0 sees a valid floor below; the top cell sees free space above.
   genvar g;
   generate
      for (g = 0; g < ENTRIES; g++) begin : g_cell
         logic                  above_valid, above_hole;
         logic [KEY_BITS-1:0]   above_key;
         logic [VALUE_BITS-1:0] above_value;
         logic                  below_valid, below_hole;

         if (g == ENTRIES - 1) begin : g_top
            assign above_valid = 1'b0;
            assign above_hole  = 1'b0;
            assign above_key   = '0;
            assign above_value = '0;
         end else begin : g_mid
            assign above_valid = flags[g+1].valid;
            assign above_hole  = flags[g+1].hole;
            assign above_key   = cell_key[g+1];
            assign above_value = cell_value[g+1];
         end

         if (g == 0) begin : g_bottom
            assign below_valid = 1'b1;
            assign below_hole  = 1'b0;
         end else begin : g_upper
            assign below_valid = flags[g-1].valid;
            assign below_hole  = flags[g-1].hole;
         end

         kvt_cell #(
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .cmd_key     (key_ff),
            .cmd_value   (value_ff),
            .above_valid (above_valid),
            .above_hole  (above_hole),
            .above_key   (above_key),
            .above_value (above_value),
            .below_valid (below_valid),
            .below_hole  (below_hole),
            .key_out     (cell_key[g]),
            .value_out   (cell_value[g]),
            .flags       (flags[g])
         );
      end
   endgenerate

   // Keys are unique, so at most one cell reports a key hit and the OR is a select.
   always_comb begin
      any_key_hit   = 1'b0;
      any_value_hit = 1'b0;
      any_hole      = 1'b0;
      any_retire    = 1'b0;
      hit_value     = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         any_key_hit   = any_key_hit | flags[i].key_hit;
         any_value_hit = any_value_hit | flags[i].value_hit;
         any_hole      = any_hole | flags[i].hole;
         any_retire    = any_retire | flags[i].retire;
         hit_value     = hit_value | (cell_value[i] & {VALUE_BITS{flags[i].key_hit}});
      end
   end

   // Controller: execute the command across the chain, compact if needed, then
   // hand the result to the output register once it is free.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      vout_in      = vout_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ctrl         = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            status_in = STATUS_OK;
            vout_in   = '0;
            state_in  = S_DONE;
            case (act_ff)
               ACT_PUT: begin
                  ctrl.put = 1'b1;
                  if (!any_key_hit) begin
                     if (full) begin
                        status_in = STATUS_FULL;
                     end else begin
                        ctrl.append = 1'b1;
                        count_in    = count_ff + COUNT_W'(1);
                     end
                  end
               end
               ACT_GET: begin
                  if (any_key_hit) begin
                     vout_in = hit_value_ext[FIELD_W-1:0];
                  end else begin
                     status_in = STATUS_ABSENT;
                  end
               end
               ACT_REMOVE_KEY: begin
                  ctrl.remove_key = 1'b1;
                  if (any_key_hit) begin
                     state_in = S_COMPACT;
                  end else begin
                     status_in = STATUS_ABSENT;
                  end
               end
               ACT_REMOVE_VALUE: begin
                  ctrl.remove_value = 1'b1;
                  if (any_value_hit) begin
                     state_in = S_COMPACT;
                  end else begin
                     status_in = STATUS_ABSENT;
                  end
               end
               ACT_CLEAR: begin
                  ctrl.clear = 1'b1;
                  count_in   = '0;
               end
               default: begin
               end
            endcase
            // Results without compaction go straight out when the slot is free.
            if (state_in == S_DONE && slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, USED_W'(count_in), vout_in, status_in};
               state_in     = S_IDLE;
            end
         end
         S_COMPACT: begin
            ctrl.step = 1'b1;
            if (any_retire) begin
               count_in = count_ff - COUNT_W'(1);
            end
            if (!any_hole) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, USED_W'(count_ff), vout_ff, status_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff   <= req_tdata[2:0];
         key_ff   <= req_key_ext[KEY_BITS-1:0];
         value_ff <= req_value_ext[VALUE_BITS-1:0];
      end
      status_ff   <= status_in;
      vout_ff     <= vout_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: rtl/kvt_cell.sv
module kvt_cell #(
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  kvt_pkg::cell_ctrl_type  ctrl,
   input  logic [KEY_BITS-1:0]     cmd_key,
   input  logic [VALUE_BITS-1:0]   cmd_value,
   input  logic                    above_valid,
   input  logic                    above_hole,
   input  logic [KEY_BITS-1:0]     above_key,
   input  logic [VALUE_BITS-1:0]   above_value,
   input  logic                    below_valid,
   input  logic                    below_hole,
   output logic [KEY_BITS-1:0]     key_out,
   output logic [VALUE_BITS-1:0]   value_out,
   output kvt_pkg::cell_flags_type flags
);
   import kvt_pkg::*;

   logic                  valid_ff, valid_in;
   logic                  hole_ff, hole_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic                  key_hit, value_hit, first_free;
   logic                  take, give, retire;

   assign key_hit    = valid_ff && (key_ff == cmd_key);
   assign value_hit  = valid_ff && (value_ff == cmd_value);
   assign first_free = !valid_ff && !hole_ff && below_valid;

   // A hole swaps upward with a valid neighbor; a hole under free space is released.
   assign take   = hole_ff && above_valid;
   assign give   = valid_ff && below_hole;
   assign retire = hole_ff && !above_valid && !above_hole;

   always_comb begin
      valid_in = valid_ff;
      hole_in  = hole_ff;
      key_in   = key_ff;
      value_in = value_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
         hole_in  = 1'b0;
      end else if (ctrl.put && key_hit) begin
         value_in = cmd_value;
      end else if (ctrl.append && first_free) begin
         valid_in = 1'b1;
         key_in   = cmd_key;
         value_in = cmd_value;
      end else if ((ctrl.remove_key && key_hit) || (ctrl.remove_value && value_hit)) begin
         valid_in = 1'b0;
         hole_in  = 1'b1;
      end else if (ctrl.step) begin
         if (take) begin
            valid_in = 1'b1;
            hole_in  = 1'b0;
            key_in   = above_key;
            value_in = above_value;
         end else if (give) begin
            valid_in = 1'b0;
            hole_in  = 1'b1;
         end else if (retire) begin
            hole_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hole_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         hole_ff  <= hole_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign key_out         = key_ff;
   assign value_out       = value_ff;
   assign flags.valid     = valid_ff;
   assign flags.hole      = hole_ff;
   assign flags.key_hit   = key_hit;
   assign flags.value_hit = value_hit;
   assign flags.retire    = retire;

endmodule

FILE: rtl/kvt_checker.sv
`include "assert_macros.svh"

module kvt_checker #(
   parameter int ENTRIES = 16
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [kvt_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import kvt_pkg::*;

   // A stalled response word keeps its contents.
   `KVT_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "response word changed while stalled")

   // Each accepted request is executed before the next one is taken.
   `KVT_ASSERT(a_one_at_a_time, req_tvalid && req_tready |=> !req_tready, "request taken during execution")

   // A full refusal only happens with every entry in use.
   `KVT_ASSERT(a_full_count, rsp_tvalid && rsp_tdata[1:0] == STATUS_FULL |-> rsp_tdata[38:34] == 5'(ENTRIES), "full status with free entries")

   // A returned value always comes with a found status.
   `KVT_ASSERT(a_value_found, rsp_tvalid && rsp_tdata[33:2] != 32'd0 |-> rsp_tdata[1:0] == STATUS_OK, "value returned without a hit")

endmodule

bind key_value_table kvt_checker #(.ENTRIES(ENTRIES)) u_kvt_checker (.*);
